[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types for the buddy page allocator: result codes, datapath
// micro-operations and the command and status bundles between the modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_BAD    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP       = 4'd0,
    DP_CLEAR     = 4'd1,
    DP_LOAD      = 4'd2,
    DP_J_INC     = 4'd3,
    DP_POP_RD    = 4'd4,
    DP_POP_WR    = 4'd5,
    DP_FLAG_RD   = 4'd6,
    DP_FLAG_WR   = 4'd7,
    DP_SPLIT     = 4'd8,
    DP_PUSH      = 4'd9,
    DP_WALK_INIT = 4'd10,
    DP_WALK_RD   = 4'd11,
    DP_WALK_STEP = 4'd12,
    DP_MERGE     = 4'd13,
    DP_RESULT    = 4'd14
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    cnt_add;
    logic    cnt_sub;
    status_e res;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic lvl_bad;
    logic page_bad;
    logic is_alloc;
    logic j_over;
    logic head_nil;
    logic j_gt_lv;
    logic j_is_max;
    logic flag_bit;
    logic walk_end;
    logic walk_hit;
  } dp_sts_t;

endpackage

[src/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: issues one datapath micro-operation per cycle
// for the clearing pass, allocate (search, pop, split) and free (merge walk).
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  bpa_pkg::dp_sts_t   sts_i,
  output bpa_pkg::ctl_cmd_t  cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'h0001,
    S_IDLE   = 14'h0002,
    S_CHECK  = 14'h0004,
    S_ASRCH  = 14'h0008,
    S_POPWR  = 14'h0010,
    S_TGRD   = 14'h0020,
    S_TGWR   = 14'h0040,
    S_SPLIT  = 14'h0080,
    S_FCHK   = 14'h0100,
    S_FDEC   = 14'h0200,
    S_WRD    = 14'h0400,
    S_WSTEP  = 14'h0800,
    S_MERGE  = 14'h1000,
    S_RESULT = 14'h2000
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '{op: DP_NOP, cnt_add: 1'b0, cnt_sub: 1'b0, res: st_q};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.lvl_bad || (!sts_i.is_alloc && sts_i.page_bad)) begin
          st_d    = ST_BAD;
          state_d = S_RESULT;
        end else if (sts_i.is_alloc) begin
          state_d = S_ASRCH;
        end else begin
          cmd_o.cnt_add = 1'b1;
          state_d       = S_TGRD;
        end
      end
      S_ASRCH: begin
        if (sts_i.j_over) begin
          st_d    = ST_NOFREE;
          state_d = S_RESULT;
        end else if (!sts_i.head_nil) begin
          cmd_o.op = DP_POP_RD;
          state_d  = S_POPWR;
        end else begin
          cmd_o.op = DP_J_INC;
        end
      end
      S_POPWR: begin
        cmd_o.op      = DP_POP_WR;
        cmd_o.cnt_sub = 1'b1;
        state_d       = S_TGRD;
      end
      S_TGRD: begin
        cmd_o.op = DP_FLAG_RD;
        state_d  = S_TGWR;
      end
      S_TGWR: begin
        cmd_o.op = DP_FLAG_WR;
        if (!sts_i.is_alloc) begin
          state_d = S_FCHK;
        end else if (sts_i.j_gt_lv) begin
          state_d = S_SPLIT;
        end else begin
          st_d    = ST_OK;
          state_d = S_RESULT;
        end
      end
      S_SPLIT: begin
        cmd_o.op = DP_SPLIT;
        state_d  = S_TGRD;
      end
      S_FCHK: begin
        if (sts_i.j_is_max) begin
          cmd_o.op = DP_PUSH;
          st_d     = ST_OK;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = DP_FLAG_RD;
          state_d  = S_FDEC;
        end
      end
      S_FDEC: begin
        if (sts_i.flag_bit) begin
          cmd_o.op = DP_PUSH;
          st_d     = ST_OK;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = DP_WALK_INIT;
          state_d  = S_WRD;
        end
      end
      S_WRD: begin
        // buddy not on its list: merge anyway, nothing to unlink
        if (sts_i.walk_end) begin
          state_d = S_MERGE;
        end else begin
          cmd_o.op = DP_WALK_RD;
          state_d  = S_WSTEP;
        end
      end
      S_WSTEP: begin
        cmd_o.op = DP_WALK_STEP;
        state_d  = sts_i.walk_hit ? S_MERGE : S_WRD;
      end
      S_MERGE: begin
        cmd_o.op = DP_MERGE;
        state_d  = S_TGRD;
      end
      S_RESULT: begin
        cmd_o.op = DP_RESULT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

[src/bpa_dpath.sv]
// ----------------------------------------------------------------------------
// bpa_dpath
// Datapath of the allocator: list heads, link and pair-flag memories,
// walk registers, free-page counter and the result register.
// ----------------------------------------------------------------------------
module bpa_dpath #(
  parameter int NUM_LEVELS = 10,
  parameter int PAGE_COUNT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpa_pkg::ctl_cmd_t                 cmd_i,
  output bpa_pkg::dp_sts_t                  sts_o,
  input  logic                              kind_i,
  input  logic [$clog2(NUM_LEVELS+1)-1:0]   level_i,
  input  logic [$clog2(PAGE_COUNT)-1:0]     page_i,
  output logic                              done_o,
  output logic [$clog2(PAGE_COUNT)-1:0]     page_out_o,
  output logic [1:0]                        status_o,
  output logic [$clog2(PAGE_COUNT+1)-1:0]   free_pages_o
);
  import bpa_pkg::*;

  localparam int PAW        = $clog2(PAGE_COUNT);
  localparam int LKW        = $clog2(PAGE_COUNT + 1);
  localparam int LW         = $clog2(NUM_LEVELS + 1);
  localparam int JW         = $clog2(NUM_LEVELS + 2);
  localparam int HIW        = $clog2(NUM_LEVELS);
  localparam int WW         = ((LKW > NUM_LEVELS) ? LKW : NUM_LEVELS) + 2;
  localparam int TOP_SIZE   = 1 << (NUM_LEVELS - 1);
  localparam int SPAN       = (PAGE_COUNT / TOP_SIZE) * TOP_SIZE;
  localparam int TOP_CNT    = SPAN / TOP_SIZE;
  localparam int FLAG_DEPTH = PAGE_COUNT + NUM_LEVELS + 1;
  localparam int FAW        = $clog2(FLAG_DEPTH);

  localparam logic [LKW-1:0] NIL_V  = LKW'(PAGE_COUNT);
  localparam logic [LKW-1:0] SPAN_V = LKW'(SPAN);

  // first flag of each level: sum of the pair counts of the levels below
  function automatic int base_f(int lidx);
    int acc;
    acc = 0;
    for (int l = 1; l <= lidx; l++) acc = acc + ((PAGE_COUNT + (1 << l) - 1) >> l);
    return acc;
  endfunction

  function automatic logic [WW-1:0] blk_f(logic [JW-1:0] lv);
    return WW'(1) << (lv - JW'(1));
  endfunction

  function automatic logic [HIW-1:0] hidx_f(logic [JW-1:0] lv);
    logic [JW-1:0] t;
    t = lv - JW'(1);
    return t[HIW-1:0];
  endfunction

  logic [WW-1:0] lvl_base [NUM_LEVELS];
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_base
    assign lvl_base[g] = WW'(base_f(g));
  end

  logic           kind_q;
  logic [LW-1:0]  lv_q;
  logic [PAW-1:0] pg_in_q;
  logic [JW-1:0]  j_q;
  logic [PAW-1:0] p_q;
  logic [PAW-1:0] bud_q;
  logic [LKW-1:0] prev_q, cur_q, steps_q;
  logic [LKW-1:0] head_q [NUM_LEVELS];
  logic [LKW-1:0] free_q;
  logic [FAW-1:0] clr_q;

  logic [LKW-1:0] link_mem [PAGE_COUNT];
  logic           flag_mem [FLAG_DEPTH];
  logic [LKW-1:0] link_rd_q;
  logic           flag_rd_q;
  logic           fidx_ok_q;

  logic           done_q;
  logic [1:0]     status_q;
  logic [PAW-1:0] page_out_q;
  logic [LKW-1:0] free_out_q;

  logic [WW-1:0]  blk_j, blk_lv, fidx_w, split_tgt, clr_w, cnt_sum;
  logic [JW-1:0]  jm;
  logic [LKW-1:0] head_j, head_jm;
  logic           fidx_ok, split_ok;

  logic           lk_we, lk_re, fl_we, fl_re, fl_wd;
  logic [PAW-1:0] lk_wa, lk_ra;
  logic [LKW-1:0] lk_wd;
  logic [FAW-1:0] fl_wa, fl_ra;

  assign blk_j     = blk_f(j_q);
  assign blk_lv    = blk_f(JW'(lv_q));
  assign jm        = j_q - JW'(1);
  assign head_j    = head_q[hidx_f(j_q)];
  assign head_jm   = head_q[hidx_f(jm)];
  assign fidx_w    = lvl_base[hidx_f(j_q)] + (WW'(p_q) >> j_q);
  assign fidx_ok   = fidx_w < WW'(FLAG_DEPTH);
  assign split_tgt = WW'(p_q) + blk_f(jm);
  assign split_ok  = split_tgt < WW'(PAGE_COUNT);
  assign clr_w     = WW'(clr_q);
  assign cnt_sum   = WW'(free_q) + blk_lv;

  always_comb begin
    sts_o.clr_last = (clr_q == FAW'(FLAG_DEPTH - 1));
    sts_o.lvl_bad  = (lv_q == '0) || (LKW'(lv_q) > LKW'(NUM_LEVELS));
    sts_o.page_bad = ((WW'(pg_in_q) & (blk_lv - WW'(1))) != '0) ||
                     ((WW'(pg_in_q) + blk_lv) > WW'(SPAN));
    sts_o.is_alloc = !kind_q;
    sts_o.j_over   = (WW'(j_q) > WW'(NUM_LEVELS));
    sts_o.head_nil = (head_j >= NIL_V);
    sts_o.j_gt_lv  = (j_q > JW'(lv_q));
    sts_o.j_is_max = (WW'(j_q) == WW'(NUM_LEVELS));
    sts_o.flag_bit = flag_rd_q && fidx_ok_q;
    sts_o.walk_end = (cur_q >= NIL_V) || (steps_q >= NIL_V);
    sts_o.walk_hit = (cur_q == LKW'(bud_q));
  end

  // memory port decode
  always_comb begin
    lk_we = 1'b0;
    lk_wa = '0;
    lk_wd = '0;
    lk_re = 1'b0;
    lk_ra = '0;
    fl_we = 1'b0;
    fl_wa = FAW'(fidx_w);
    fl_wd = 1'b0;
    fl_re = 1'b0;
    fl_ra = FAW'(fidx_w);
    unique case (cmd_i.op)
      DP_CLEAR: begin
        fl_we = 1'b1;
        fl_wa = clr_q;
        if (clr_w < WW'(TOP_CNT)) begin
          lk_we = 1'b1;
          lk_wa = PAW'(clr_w << (NUM_LEVELS - 1));
          lk_wd = ((clr_w + WW'(1)) < WW'(TOP_CNT)) ?
                  LKW'((clr_w + WW'(1)) << (NUM_LEVELS - 1)) : NIL_V;
        end
      end
      DP_POP_RD: begin
        lk_re = 1'b1;
        lk_ra = PAW'(head_j);
      end
      DP_FLAG_RD: fl_re = 1'b1;
      DP_FLAG_WR: begin
        fl_we = fidx_ok;
        fl_wd = !flag_rd_q;
      end
      DP_SPLIT: begin
        lk_we = split_ok;
        lk_wa = PAW'(split_tgt);
        lk_wd = head_jm;
      end
      DP_PUSH: begin
        lk_we = 1'b1;
        lk_wa = p_q;
        lk_wd = head_j;
      end
      DP_WALK_RD: begin
        lk_re = 1'b1;
        lk_ra = PAW'(cur_q);
      end
      DP_WALK_STEP: begin
        // unlink from a predecessor; a hit at the head goes to head_q
        if (sts_o.walk_hit && (prev_q < NIL_V)) begin
          lk_we = 1'b1;
          lk_wa = PAW'(prev_q);
          lk_wd = link_rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (lk_re) link_rd_q <= link_mem[lk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) flag_mem[fl_wa] <= fl_wd;
    if (fl_re) flag_rd_q <= flag_mem[fl_ra];
  end

  // control state: heads, counter, clearing pointer, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= ((l == NUM_LEVELS - 1) && (TOP_CNT > 0)) ? LKW'(0) : NIL_V;
      end
      free_q <= SPAN_V;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == DP_RESULT);
      if (cmd_i.cnt_sub) begin
        free_q <= (WW'(free_q) > blk_lv) ? LKW'(WW'(free_q) - blk_lv) : '0;
      end else if (cmd_i.cnt_add) begin
        free_q <= (cnt_sum > WW'(SPAN)) ? SPAN_V : LKW'(cnt_sum);
      end
      unique case (cmd_i.op)
        DP_CLEAR:  clr_q <= clr_q + FAW'(1);
        DP_POP_WR: head_q[hidx_f(j_q)] <= link_rd_q;
        DP_SPLIT: begin
          if (split_ok) head_q[hidx_f(jm)] <= LKW'(split_tgt);
        end
        DP_PUSH:   head_q[hidx_f(j_q)] <= LKW'(p_q);
        DP_WALK_STEP: begin
          if (sts_o.walk_hit && (prev_q >= NIL_V)) head_q[hidx_f(j_q)] <= link_rd_q;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        kind_q  <= kind_i;
        lv_q    <= level_i;
        pg_in_q <= page_i;
        j_q     <= JW'(level_i);
        p_q     <= page_i;
      end
      DP_J_INC:   j_q <= j_q + JW'(1);
      DP_POP_RD:  p_q <= PAW'(head_j);
      DP_FLAG_RD: fidx_ok_q <= fidx_ok;
      DP_SPLIT:   j_q <= jm;
      DP_WALK_INIT: begin
        bud_q   <= p_q ^ PAW'(blk_j);
        prev_q  <= NIL_V;
        cur_q   <= head_j;
        steps_q <= '0;
      end
      DP_WALK_STEP: begin
        if (!sts_o.walk_hit) begin
          prev_q  <= cur_q;
          cur_q   <= link_rd_q;
          steps_q <= steps_q + LKW'(1);
        end
      end
      DP_MERGE: begin
        p_q <= p_q & ~PAW'(blk_j);
        j_q <= j_q + JW'(1);
      end
      DP_RESULT: begin
        status_q   <= cmd_i.res;
        page_out_q <= (!kind_q && (cmd_i.res == ST_OK)) ? p_q : '0;
        free_out_q <= free_q;
      end
      default: begin
      end
    endcase
  end

  assign done_o       = done_q;
  assign page_out_o   = page_out_q;
  assign status_o     = status_q;
  assign free_pages_o = free_out_q;

endmodule

[src/buddy_page_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator with per-level LIFO free lists and pair flags.
// ----------------------------------------------------------------------------
// A request transfers when start_i is high and busy_o is low; its single
// result appears for one cycle with done_o high and must be taken then.
// After reset a clearing pass zeroes the pair flags and links the top blocks;
// busy_o stays high. After a transfer busy_o stays high while the request
// runs: an allocate searches up the levels for a non-empty list, pops its
// head and splits down to the requested level; a free merges with its buddy
// level by level, walking the buddy's list to unlink it; a bad request goes
// straight to its result.
// The sequencer issues one micro-operation per cycle on single-port memories.
// done_o rises in the same cycle as busy_o falls, where a new request may
// already transfer.
module buddy_page_allocator #(
  parameter int NUM_LEVELS = 10,
  parameter int PAGE_COUNT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              kind_i,
  input  logic [$clog2(NUM_LEVELS+1)-1:0]   level_i,
  input  logic [$clog2(PAGE_COUNT)-1:0]     page_i,
  output logic                              done_o,
  output logic [$clog2(PAGE_COUNT)-1:0]     page_out_o,
  output logic [1:0]                        status_o,
  output logic [$clog2(PAGE_COUNT+1)-1:0]   free_pages_o
);
  import bpa_pkg::*;

  localparam int TOP_SIZE = 1 << (NUM_LEVELS - 1);
  localparam int SPAN     = (PAGE_COUNT / TOP_SIZE) * TOP_SIZE;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  bpa_dpath #(
    .NUM_LEVELS (NUM_LEVELS),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .level_i      (level_i),
    .page_i       (page_i),
    .done_o       (done_o),
    .page_out_o   (page_out_o),
    .status_o     (status_o),
    .free_pages_o (free_pages_o)
  );

  a_fail_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (page_out_o == '0))
    else $error("failed request reports a nonzero page");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(free_pages_o) <= SPAN))
    else $error("free page count above span");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted request did not start work");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule
